>>> design/rdcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcc_pkg
// Types and constants shared by the radio duty-cycle controller files.
// ----------------------------------------------------------------------------
package rdcc_pkg;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int NOW_W     = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TICK_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOOT_GRACE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOT_START     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAKE          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_DEFAULT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_RECENT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RECENCY       = 3'd6;

    // Register reset values, in milliseconds
    localparam logic [15:0]      TICK_INTERVAL_RST = 16'd1000;
    localparam logic [CFG_W-1:0] BOOT_GRACE_RST    = 32'd600000;
    localparam logic [CFG_W-1:0] HOT_START_RST     = 32'd300000;
    localparam logic [CFG_W-1:0] WAKE_RST          = 32'd20000;
    localparam logic [CFG_W-1:0] SLEEP_DEFAULT_RST = 32'd40000;
    localparam logic [CFG_W-1:0] SLEEP_RECENT_RST  = 32'd20000;
    localparam logic [CFG_W-1:0] RECENCY_RST       = 32'd600000;

    typedef enum logic [2:0] {
        MODE_BOOT  = 3'd0,
        MODE_AWAKE = 3'd1,
        MODE_HOT   = 3'd2,
        MODE_WAKE  = 3'd3,
        MODE_SLEEP = 3'd4,
        MODE_OFF   = 3'd5
    } mode_t;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef struct packed {
        logic [15:0]      tick_gap_ms;
        logic [CFG_W-1:0] grace_ms;
        logic [CFG_W-1:0] hot_ms;
        logic [CFG_W-1:0] wake_ms;
        logic [CFG_W-1:0] sleep_long_ms;
        logic [CFG_W-1:0] sleep_recent_ms;
        logic [CFG_W-1:0] recent_win_ms;
    } cfg_t;

    typedef struct packed {
        logic             op;
        logic [NOW_W-1:0] now_ms;
        logic             link_connected;
        logic             user_enable;
        logic             role_allows;
    } item_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       evaluated;
        logic       power_on_strobe;
        logic       power_off_strobe;
    } result_t;

endpackage

>>> design/rdcc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcc_if
// Valid/ready channels for the tick word and the result word.
// ----------------------------------------------------------------------------
interface rdcc_item_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] now_ms;
    logic        link_connected;
    logic        user_enable;
    logic        role_allows;

    modport source (output valid, op, now_ms, link_connected, user_enable, role_allows,
                    input ready);
    modport sink (input valid, op, now_ms, link_connected, user_enable, role_allows,
                  output ready);
endinterface

interface rdcc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic       evaluated;
    logic       power_on_strobe;
    logic       power_off_strobe;

    modport source (output valid, mode, evaluated, power_on_strobe, power_off_strobe,
                    input ready);
    modport sink (input valid, mode, evaluated, power_on_strobe, power_off_strobe,
                  output ready);
endinterface

>>> design/radio_duty_cycle_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_duty_cycle_controller_unit
// Radio power duty-cycler: one result word for every tick or restart word.
// ----------------------------------------------------------------------------
// Takes one word per clock cycle while the result side does not stall; the
// word is captured in an input register, the phase update and all deadline
// adds run in combinational logic, and the result lands in an output
// register. When the result side stalls, the input register holds one
// more word and the input stalls after it. The phase state advances exactly
// when a word moves from the input register into the output register, so
// consecutive words see each other's updates with no bubble. Configuration
// writes take effect on the next cycle and are meant for idle periods.
module radio_duty_cycle_controller_unit #(
    parameter int TIME_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rdcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rdcc_pkg::CFG_W-1:0]     cfg_wdata,
    rdcc_item_if.sink                      item,
    rdcc_result_if.source                  result
);
    import rdcc_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res_next;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;
    logic    take;

    rdcc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rdcc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res_next)
    );

    // Move the held word forward when the output register is free or draining
    assign advance    = item_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;
    assign take       = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item.ready)
                item_valid_reg <= item.valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.op             <= item.op;
            item_reg.now_ms         <= item.now_ms;
            item_reg.link_connected <= item.link_connected;
            item_reg.user_enable    <= item.user_enable;
            item_reg.role_allows    <= item.role_allows;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign result.valid            = res_valid_reg;
    assign result.mode             = res_reg.mode;
    assign result.evaluated        = res_reg.evaluated;
    assign result.power_on_strobe  = res_reg.power_on_strobe;
    assign result.power_off_strobe = res_reg.power_off_strobe;

endmodule

>>> design/rdcc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcc_cfg_regs
// Configuration register file: write-only, reset to the default timings.
// ----------------------------------------------------------------------------
module rdcc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rdcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rdcc_pkg::CFG_W-1:0]     cfg_wdata,
    output rdcc_pkg::cfg_t                 cfg
);
    import rdcc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TICK_INTERVAL: cfg_next.tick_gap_ms     = cfg_wdata[15:0];
                REG_BOOT_GRACE:    cfg_next.grace_ms        = cfg_wdata;
                REG_HOT_START:     cfg_next.hot_ms          = cfg_wdata;
                REG_WAKE:          cfg_next.wake_ms         = cfg_wdata;
                REG_SLEEP_DEFAULT: cfg_next.sleep_long_ms   = cfg_wdata;
                REG_SLEEP_RECENT:  cfg_next.sleep_recent_ms = cfg_wdata;
                REG_RECENCY:       cfg_next.recent_win_ms   = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_gap_ms     <= TICK_INTERVAL_RST;
            cfg_reg.grace_ms        <= BOOT_GRACE_RST;
            cfg_reg.hot_ms          <= HOT_START_RST;
            cfg_reg.wake_ms         <= WAKE_RST;
            cfg_reg.sleep_long_ms   <= SLEEP_DEFAULT_RST;
            cfg_reg.sleep_recent_ms <= SLEEP_RECENT_RST;
            cfg_reg.recent_win_ms   <= RECENCY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/rdcc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcc_core
// Phase state, deadlines and issued-command flag, stepped once per word.
// ----------------------------------------------------------------------------
module rdcc_core #(
    parameter int TIME_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  rdcc_pkg::item_t   item,
    input  rdcc_pkg::cfg_t    cfg,
    output rdcc_pkg::result_t res
);
    import rdcc_pkg::*;

    // Wide enough for both a time value and a 32-bit register
    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

    typedef logic [TIME_BITS-1:0] time_t;

    function automatic time_t add_ms(input time_t a, input logic [CFG_W-1:0] b);
        logic [CMP_W-1:0] sum;
        sum = CMP_W'(a) + CMP_W'(b);
        return sum[TIME_BITS-1:0];
    endfunction

    function automatic logic below(input time_t d, input logic [CFG_W-1:0] c);
        return CMP_W'(d) < CMP_W'(c);
    endfunction

    logic [2:0] phase_reg, phase_next;
    time_t      last_eval_reg, last_eval_next;
    time_t      grace_reg, grace_next;
    time_t      hot_reg, hot_next;
    time_t      wake_reg, wake_next;
    time_t      sleep_reg, sleep_next;
    time_t      disc_reg, disc_next;
    logic       issued_reg, issued_next;

    logic [CMP_W-1:0] now_ext;
    logic [CMP_W-1:0] grace_rst_ext;
    time_t            now_t;
    time_t            boot_dl;
    time_t            hot_dl;
    time_t            wake_dl;
    time_t            sleep_dl;
    logic             recent;
    logic             evaluate;
    logic [2:0]       cur;
    time_t            grace_cur;
    logic             on_stb;
    logic             off_stb;

    assign now_ext       = CMP_W'(item.now_ms);
    assign now_t         = now_ext[TIME_BITS-1:0];
    assign grace_rst_ext = CMP_W'(BOOT_GRACE_RST);

    // All candidate deadlines are formed in parallel; the phase logic picks
    assign boot_dl  = add_ms(now_t, cfg.grace_ms);
    assign hot_dl   = add_ms(now_t, cfg.hot_ms);
    assign wake_dl  = add_ms(now_t, cfg.wake_ms);
    assign recent   = (disc_reg != '0) && below(now_t - disc_reg, cfg.recent_win_ms);
    assign sleep_dl = recent ? add_ms(now_t, cfg.sleep_recent_ms)
                             : add_ms(now_t, cfg.sleep_long_ms);
    assign evaluate = !below(now_t - last_eval_reg, {16'd0, cfg.tick_gap_ms});

    always_comb
    begin
        phase_next     = phase_reg;
        last_eval_next = last_eval_reg;
        grace_next     = grace_reg;
        hot_next       = hot_reg;
        wake_next      = wake_reg;
        sleep_next     = sleep_reg;
        disc_next      = disc_reg;
        issued_next    = issued_reg;
        on_stb         = 1'b0;
        off_stb        = 1'b0;
        cur            = phase_reg;
        grace_cur      = grace_reg;

        if (item.op == OP_RESTART)
        begin
            phase_next  = MODE_BOOT;
            grace_next  = boot_dl;
            issued_next = 1'b0;
        end
        else if (evaluate)
        begin
            last_eval_next = now_t;
            if (!item.user_enable || !item.role_allows)
            begin
                phase_next  = MODE_OFF;
                off_stb     = issued_reg;
                issued_next = 1'b0;
            end
            else
            begin
                // Leaving permanent off restarts boot grace in the same tick
                if (phase_reg == MODE_OFF)
                begin
                    cur       = MODE_BOOT;
                    grace_cur = boot_dl;
                end
                grace_next = grace_cur;
                phase_next = cur;
                case (cur)
                    MODE_BOOT:
                    begin
                        on_stb      = !issued_reg;
                        issued_next = 1'b1;
                        if (item.link_connected)
                            phase_next = MODE_AWAKE;
                        else if (now_t >= grace_cur)
                        begin
                            phase_next = MODE_HOT;
                            hot_next   = hot_dl;
                        end
                    end
                    MODE_AWAKE:
                    begin
                        on_stb      = !issued_reg;
                        issued_next = 1'b1;
                        if (!item.link_connected)
                        begin
                            disc_next  = now_t;
                            phase_next = MODE_HOT;
                            hot_next   = hot_dl;
                        end
                    end
                    MODE_HOT:
                    begin
                        on_stb      = !issued_reg;
                        issued_next = 1'b1;
                        if (item.link_connected)
                            phase_next = MODE_AWAKE;
                        else if (now_t >= hot_reg)
                        begin
                            phase_next = MODE_SLEEP;
                            sleep_next = sleep_dl;
                        end
                    end
                    MODE_WAKE:
                    begin
                        on_stb      = !issued_reg;
                        issued_next = 1'b1;
                        if (item.link_connected)
                            phase_next = MODE_AWAKE;
                        else if (now_t >= wake_reg)
                        begin
                            phase_next = MODE_SLEEP;
                            sleep_next = sleep_dl;
                        end
                    end
                    MODE_SLEEP:
                    begin
                        off_stb     = issued_reg;
                        issued_next = 1'b0;
                        if (now_t >= sleep_reg)
                        begin
                            phase_next = MODE_WAKE;
                            wake_next  = wake_dl;
                        end
                    end
                    default:
                    begin
                        phase_next = cur;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= MODE_BOOT;
            last_eval_reg <= '0;
            grace_reg     <= grace_rst_ext[TIME_BITS-1:0];
            hot_reg       <= '0;
            wake_reg      <= '0;
            sleep_reg     <= '0;
            disc_reg      <= '0;
            issued_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            last_eval_reg <= last_eval_next;
            grace_reg     <= grace_next;
            hot_reg       <= hot_next;
            wake_reg      <= wake_next;
            sleep_reg     <= sleep_next;
            disc_reg      <= disc_next;
            issued_reg    <= issued_next;
        end
    end

    assign res.mode             = phase_next;
    assign res.evaluated        = (item.op == OP_TICK) && evaluate;
    assign res.power_on_strobe  = on_stb;
    assign res.power_off_strobe = off_stb;

endmodule

>>> design/rdcc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcc_checker
// Port-level assertions for the duty-cycle controller, bound to the top level.
// ----------------------------------------------------------------------------
module rdcc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] res_mode,
    input logic       res_evaluated,
    input logic       res_on,
    input logic       res_off
);
    import rdcc_pkg::*;

    // A word never asks for power up and tear down at once
    a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_on && res_off))
        else $error("both power strobes in one result word");

    // Throttled ticks and restarts never strobe
    a_strobe_eval: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_on || res_off) |-> res_evaluated)
        else $error("power strobe on a word that was not evaluated");

    // Permanent off never powers the radio up
    a_off_no_on: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_mode == MODE_OFF) |-> !res_on)
        else $error("power-on strobe in permanent-off mode");

    // A stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_mode)
            && $stable(res_on) && $stable(res_off))
        else $error("result word changed while stalled");

endmodule

bind radio_duty_cycle_controller_unit rdcc_checker u_rdcc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_mode      (result.mode),
    .res_evaluated (result.evaluated),
    .res_on        (result.power_on_strobe),
    .res_off       (result.power_off_strobe)
);
